// ----- rtl/heq_pkg.sv -----
// ----------------------------------------------------------------------------
// heq_pkg
// Shared constants, request codes and controller/datapath interface types
// for the histogram equalizer.
// ----------------------------------------------------------------------------
package heq_pkg;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned NBINS      = 1 << PIX_W;
	localparam int unsigned MAX_PIXELS = 1048576;
	localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);
	localparam int unsigned DIV_W      = CNT_W + PIX_W;
	localparam int unsigned STEP_W     = $clog2(PIX_W);

	localparam logic [CNT_W-1:0] MAX_TOTAL = CNT_W'(MAX_PIXELS);

	localparam logic [1:0] REQ_COUNT = 2'd0;
	localparam logic [1:0] REQ_BUILD = 2'd1;
	localparam logic [1:0] REQ_MAP   = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	typedef struct packed {
		logic bin_rd;
		logic bin_sel_v;
		logic bin_inc;
		logic clr_all;
		logic map_clr;
		logic map_rd;
		logic out_load;
		logic bld_init;
		logic div_start;
		logic map_wr;
	} cmd_t;

	typedef struct packed {
		logic total_full;
		logic total_zero;
		logic div_done;
		logic last_bin;
		logic out_busy;
	} sts_t;

endpackage

// ----- rtl/heq_div.sv -----
// ----------------------------------------------------------------------------
// heq_div
// Restoring divider, one quotient bit per cycle, for quotients that fit in
// PIX_W bits (dividend below divisor times 2**PIX_W).
// ----------------------------------------------------------------------------
module heq_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [heq_pkg::DIV_W-1:0]   dividend,
	input  logic [heq_pkg::CNT_W-1:0]   divisor,
	output logic                        done,
	output logic [heq_pkg::PIX_W-1:0]   quotient
);
	import heq_pkg::*;

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsh_q;
	logic [PIX_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	assign fits = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(PIX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= DIV_W'({divisor, {(PIX_W-1){1'b0}}});
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[PIX_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/heq_datapath.sv -----
// ----------------------------------------------------------------------------
// heq_datapath
// Bin counts, pixel total, mapping table, cumulative sum, divider and the
// result register of the histogram equalizer.
// ----------------------------------------------------------------------------
module heq_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  heq_pkg::cmd_t             cmd,
	input  logic [heq_pkg::PIX_W-1:0] pixel_value,
	input  logic                      out_ready,
	output heq_pkg::sts_t             sts,
	output logic                      out_valid,
	output logic [heq_pkg::PIX_W-1:0] out_pixel
);
	import heq_pkg::*;

	logic [CNT_W-1:0] bin_mem [NBINS];
	logic [PIX_W-1:0] map_mem [NBINS];
	logic [NBINS-1:0] bin_vld_q;
	logic [NBINS-1:0] map_vld_q;

	logic [CNT_W-1:0] bin_rd_s1;
	logic             bin_rv_s1;
	logic [PIX_W-1:0] map_rd_s1;
	logic             map_rv_s1;
	logic [PIX_W-1:0] cnt_addr_q;
	logic [PIX_W-1:0] v_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] cum_q;
	logic [PIX_W-1:0] base_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pixel_q;

	logic [PIX_W-1:0] rd_addr;
	logic [CNT_W-1:0] bin_val;
	logic [CNT_W-1:0] cum_next;
	logic [CNT_W-1:0] num_sel;
	logic [DIV_W-1:0] dividend;
	logic             div_done;
	logic [PIX_W-1:0] quotient;
	logic [PIX_W:0]   e_sum;
	logic [PIX_W-1:0] e_val;

	assign rd_addr  = cmd.bin_sel_v ? v_q : pixel_value;
	assign bin_val  = bin_rv_s1 ? bin_rd_s1 : '0;
	assign cum_next = cum_q + bin_val;
	assign num_sel  = (v_q == '0) ? bin_val : cum_next;
	// times 255 as times 256 minus one
	assign dividend = DIV_W'({num_sel, {PIX_W{1'b0}}}) - DIV_W'(num_sel);

	heq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign e_sum = (v_q == '0) ? {1'b0, quotient}
	                           : ({1'b0, base_q} + {1'b0, quotient});
	assign e_val = e_sum[PIX_W] ? '1 : e_sum[PIX_W-1:0];

	// memories
	always_ff @(posedge clk) begin
		if (cmd.bin_rd) begin
			bin_rd_s1 <= bin_mem[rd_addr];
			bin_rv_s1 <= bin_vld_q[rd_addr];
			cnt_addr_q <= pixel_value;
		end
		if (cmd.bin_inc) begin
			bin_mem[cnt_addr_q] <= bin_val + CNT_W'(1);
		end
		if (cmd.map_rd) begin
			map_rd_s1 <= map_mem[pixel_value];
			map_rv_s1 <= map_vld_q[pixel_value];
		end
		if (cmd.map_wr) begin
			map_mem[v_q] <= e_val;
		end
	end

	// payload registers of the build walk and the result pixel register
	always_ff @(posedge clk) begin
		if (cmd.bld_init) begin
			cum_q <= '0;
		end else if (cmd.div_start && (v_q != '0)) begin
			cum_q <= cum_next;
		end
		if (cmd.map_wr && (v_q == '0)) begin
			base_q <= quotient;
		end
		if (cmd.out_load) begin
			out_pixel_q <= map_rv_s1 ? map_rd_s1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q   <= '0;
			map_vld_q   <= '0;
			total_q     <= '0;
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_all) begin
				bin_vld_q <= '0;
				map_vld_q <= '0;
				total_q   <= '0;
			end else begin
				if (cmd.bin_inc) begin
					bin_vld_q[cnt_addr_q] <= 1'b1;
					total_q <= total_q + CNT_W'(1);
				end
				if (cmd.map_clr) begin
					map_vld_q <= '0;
				end else if (cmd.map_wr) begin
					map_vld_q[v_q] <= 1'b1;
				end
			end
			if (cmd.bld_init) begin
				v_q <= '0;
			end else if (cmd.map_wr) begin
				v_q <= v_q + PIX_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.total_full = (total_q >= MAX_TOTAL);
	assign sts.total_zero = (total_q == '0);
	assign sts.div_done   = div_done;
	assign sts.last_bin   = (v_q == PIX_W'(NBINS - 1));
	assign sts.out_busy   = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;

endmodule

// ----- rtl/heq_ctrl.sv -----
// ----------------------------------------------------------------------------
// heq_ctrl
// Request sequencer of the histogram equalizer: takes one transaction at a
// time and steps the datapath through count, map, clear and the build walk.
// ----------------------------------------------------------------------------
module heq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    req_type,
	input  heq_pkg::sts_t sts,
	output logic          in_ready,
	output heq_pkg::cmd_t cmd
);
	import heq_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CNT_WR   = 3'd1;
	localparam logic [2:0] S_MAP_OUT  = 3'd2;
	localparam logic [2:0] S_BLD_RD   = 3'd3;
	localparam logic [2:0] S_BLD_ST   = 3'd4;
	localparam logic [2:0] S_BLD_WAIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_COUNT: begin
							if (!sts.total_full) begin
								cmd.bin_rd = 1'b1;
								state_nxt  = S_CNT_WR;
							end
						end
						REQ_BUILD: begin
							if (sts.total_zero) begin
								cmd.map_clr = 1'b1;
							end else begin
								cmd.bld_init = 1'b1;
								state_nxt    = S_BLD_RD;
							end
						end
						REQ_MAP: begin
							cmd.map_rd = 1'b1;
							state_nxt  = S_MAP_OUT;
						end
						REQ_CLEAR: begin
							cmd.clr_all = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_CNT_WR: begin
				cmd.bin_inc = 1'b1;
				state_nxt   = S_IDLE;
			end
			S_MAP_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_BLD_RD: begin
				cmd.bin_rd    = 1'b1;
				cmd.bin_sel_v = 1'b1;
				state_nxt     = S_BLD_ST;
			end
			S_BLD_ST: begin
				cmd.div_start = 1'b1;
				state_nxt     = S_BLD_WAIT;
			end
			S_BLD_WAIT: begin
				if (sts.div_done) begin
					cmd.map_wr = 1'b1;
					state_nxt  = sts.last_bin ? S_IDLE : S_BLD_RD;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- rtl/histogram_equalizer.sv -----
// ----------------------------------------------------------------------------
// histogram_equalizer
// 8-bit gray histogram equalization: count, build map, map pixel, clear.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. A count reads the bin, then
// increments and writes it back, or is dropped once the pixel total is at
// its limit; a map request reads the map, then loads the result register
// once it has drained; a clear and a build of an empty histogram end on
// acceptance. A build walks the 256 bins in turn through the 8-step
// restoring divider shared by every bin. The result register lets the next
// transaction in while a mapped pixel waits.
module histogram_equalizer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                req_type,
	input  logic [heq_pkg::PIX_W-1:0] pixel_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [heq_pkg::PIX_W-1:0] out_pixel
);
	import heq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	heq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	heq_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.pixel_value (pixel_value),
		.out_ready   (out_ready),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_pixel   (out_pixel)
	);

	// no pending result is overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	// map entries are written only with a finished quotient
	a_map_wr_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.map_wr |-> sts.div_done)
		else $error("map written without divider result");

	// a map transaction holds off the next one
	a_map_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (req_type == REQ_MAP)) |=> !in_ready)
		else $error("input taken during map transaction");

endmodule
